// ----- rtl/pfmt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pfmt_pkg
// shared constants, command type and digit character function for the numeric formatter
// ---------------------------------------------------------------------------
package pfmt_pkg;

  localparam int VALUE_BITS = 32;
  // argument bits taken from the 32-bit argument word
  localparam int ARG_BITS   = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
  // octal gives the longest digit string
  localparam int MAX_DIGITS = (ARG_BITS + 2) / 3;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = $clog2(MAX_DIGITS);

  // divide by ten as multiply by reciprocal, exact for 32-bit operands
  localparam int          DIV_W       = 32;
  localparam int          PROD_W      = 2 * DIV_W;
  localparam int          RECIP_SHIFT = 35;
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // format characters
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_X_LO    = 8'h78;
  localparam logic [7:0] CH_X_UP    = 8'h58;
  localparam logic [7:0] CH_O       = 8'h6F;
  localparam logic [7:0] CH_C       = 8'h63;
  localparam logic [7:0] CH_S       = 8'h73;

  // radix codes
  localparam logic [1:0] RAD_DEC = 2'd0;
  localparam logic [1:0] RAD_HEX = 2'd1;
  localparam logic [1:0] RAD_OCT = 2'd2;

  typedef struct packed {
    logic                is_num;
    logic [1:0]          radix;
    logic                neg;
    logic                unsup;
    logic [7:0]          ch;
    logic [ARG_BITS-1:0] mag;
  } cmd_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'h0, d};
    end else begin
      c = 8'h37 + {4'h0, d};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/pfmt_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pfmt_in_if
// format byte and argument channel, valid/ready handshake
// ---------------------------------------------------------------------------
interface pfmt_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  fmt_byte;
  logic [31:0] arg_value;

  modport source (output valid, output fmt_byte, output arg_value, input ready);
  modport sink   (input valid, input fmt_byte, input arg_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/pfmt_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pfmt_out_if
// character result channel, valid/ready handshake
// ---------------------------------------------------------------------------
interface pfmt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;
  logic       unsupported;

  modport source (output valid, output out_char, output last, output unsupported,
                  input ready);
  modport sink   (input valid, input out_char, input last, input unsupported,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/pfmt_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pfmt_front
// accepts format bytes, tracks a pending percent, builds back-end commands
// ---------------------------------------------------------------------------
module pfmt_front (
  input  wire logic           clk,
  input  wire logic           rst,
  pfmt_in_if.sink             in_ch,
  input  wire logic           full,
  output logic                push,
  output pfmt_pkg::cmd_t      cmd
);

  logic                          percent_pending;
  logic                          percent_pending_next;
  logic                          take;
  logic                          emit;
  logic [pfmt_pkg::ARG_BITS-1:0] arg;

  assign in_ch.ready = !full;
  assign take        = in_ch.valid && !full;
  assign arg         = in_ch.arg_value[pfmt_pkg::ARG_BITS-1:0];
  assign push        = take && emit;

  always_comb begin
    cmd                  = '0;
    cmd.ch               = in_ch.fmt_byte;
    cmd.radix            = pfmt_pkg::RAD_DEC;
    cmd.mag              = arg;
    emit                 = 1'b1;
    percent_pending_next = 1'b0;
    if (in_ch.fmt_byte == pfmt_pkg::CH_NUL) begin
      cmd.ch = pfmt_pkg::CH_NUL;
    end else if (!percent_pending) begin
      if (in_ch.fmt_byte == pfmt_pkg::CH_PERCENT) begin
        emit                 = 1'b0;
        percent_pending_next = 1'b1;
      end
    end else begin
      case (in_ch.fmt_byte)
        pfmt_pkg::CH_D: begin
          cmd.is_num = 1'b1;
          cmd.neg    = arg[pfmt_pkg::ARG_BITS-1];
          if (arg[pfmt_pkg::ARG_BITS-1]) begin
            cmd.mag = (~arg) + 1'b1;
          end
        end
        pfmt_pkg::CH_U: begin
          cmd.is_num = 1'b1;
        end
        pfmt_pkg::CH_X_LO, pfmt_pkg::CH_X_UP: begin
          cmd.is_num = 1'b1;
          cmd.radix  = pfmt_pkg::RAD_HEX;
        end
        pfmt_pkg::CH_O: begin
          cmd.is_num = 1'b1;
          cmd.radix  = pfmt_pkg::RAD_OCT;
        end
        pfmt_pkg::CH_S: begin
          cmd.ch    = pfmt_pkg::CH_NUL;
          cmd.unsup = 1'b1;
        end
        pfmt_pkg::CH_C: begin
          cmd.ch = in_ch.arg_value[7:0];
        end
        default: begin
          cmd.ch = in_ch.fmt_byte;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      percent_pending <= 1'b0;
    end else if (take) begin
      percent_pending <= percent_pending_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pfmt_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pfmt_queue
// short command fifo between front and back
// ---------------------------------------------------------------------------
module pfmt_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire pfmt_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output pfmt_pkg::cmd_t      head_cmd,
  output logic                not_empty
);

  pfmt_pkg::cmd_t                entries [pfmt_pkg::QUEUE_DEPTH];
  logic [pfmt_pkg::QPTR_W-1:0]   wr_ptr;
  logic [pfmt_pkg::QPTR_W-1:0]   rd_ptr;
  logic [pfmt_pkg::QCNT_W-1:0]   count;

  assign full      = (count == pfmt_pkg::QCNT_W'(pfmt_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_cmd  = entries[rd_ptr];

  function automatic logic [pfmt_pkg::QPTR_W-1:0] ptr_inc(
    input logic [pfmt_pkg::QPTR_W-1:0] p
  );
    logic [pfmt_pkg::QPTR_W-1:0] n;
    if (p == pfmt_pkg::QPTR_W'(pfmt_pkg::QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pfmt_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pfmt_back
// digit engine: splits the magnitude into digits, then emits characters
// ---------------------------------------------------------------------------
module pfmt_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire pfmt_pkg::cmd_t cmd,
  input  wire logic           cmd_valid,
  output logic                pop,
  pfmt_out_if.source          out_ch
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MINUS = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIG   = 3'd3;
  localparam logic [2:0] ST_POP   = 3'd4;

  logic [2:0]                    state;
  logic [1:0]                    radix;
  logic [pfmt_pkg::ARG_BITS-1:0] mag;
  logic [pfmt_pkg::PROD_W-1:0]   prod;
  logic [3:0]                    stack [pfmt_pkg::MAX_DIGITS];
  logic [pfmt_pkg::CNT_W-1:0]    cnt;
  logic                          out_valid;
  logic [7:0]                    out_char;
  logic                          out_last;
  logic                          out_unsup;

  logic                          can_load;
  logic                          load;
  logic [pfmt_pkg::ARG_BITS-1:0] q10;
  logic [pfmt_pkg::ARG_BITS-1:0] q10_x10;
  logic [pfmt_pkg::ARG_BITS-1:0] quot;
  logic [3:0]                    dig;
  logic [pfmt_pkg::IDX_W-1:0]    top_idx;
  logic [pfmt_pkg::DIV_W-1:0]    mag_ext;

  assign out_ch.valid       = out_valid;
  assign out_ch.out_char    = out_char;
  assign out_ch.last        = out_last;
  assign out_ch.unsupported = out_unsup;

  assign can_load = !out_valid || out_ch.ready;
  assign pop      = (state == ST_IDLE) && cmd_valid && (cmd.is_num || can_load);
  assign top_idx  = pfmt_pkg::IDX_W'(cnt - 1'b1);
  assign mag_ext  = pfmt_pkg::DIV_W'(mag);

  // output register takes a new character this cycle
  assign load = can_load &&
                (((state == ST_IDLE) && cmd_valid && !cmd.is_num) ||
                 (state == ST_MINUS) || (state == ST_POP));

  // quotient by ten from the registered product, remainder by shift-add
  assign q10     = pfmt_pkg::ARG_BITS'(prod >> pfmt_pkg::RECIP_SHIFT);
  assign q10_x10 = (q10 << 3) + (q10 << 1);

  always_comb begin
    case (radix)
      pfmt_pkg::RAD_HEX: begin
        dig  = mag[3:0];
        quot = mag >> 4;
      end
      pfmt_pkg::RAD_OCT: begin
        dig  = {1'b0, mag[2:0]};
        quot = mag >> 3;
      end
      default: begin
        dig  = 4'(mag - q10_x10);
        quot = q10;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            if (!cmd.is_num) begin
              if (can_load) begin
                out_char  <= cmd.ch;
                out_last  <= 1'b1;
                out_unsup <= cmd.unsup;
              end
            end else begin
              mag   <= cmd.mag;
              radix <= cmd.radix;
              cnt   <= '0;
              if (cmd.neg) begin
                state <= ST_MINUS;
              end else if (cmd.radix == pfmt_pkg::RAD_DEC) begin
                state <= ST_MUL;
              end else begin
                state <= ST_DIG;
              end
            end
          end
        end
        ST_MINUS: begin
          if (can_load) begin
            out_char  <= pfmt_pkg::CH_MINUS;
            out_last  <= 1'b0;
            out_unsup <= 1'b0;
            state     <= (radix == pfmt_pkg::RAD_DEC) ? ST_MUL : ST_DIG;
          end
        end
        ST_MUL: begin
          prod  <= {{pfmt_pkg::DIV_W{1'b0}}, mag_ext} *
                   {{pfmt_pkg::DIV_W{1'b0}}, pfmt_pkg::RECIP_TEN};
          state <= ST_DIG;
        end
        ST_DIG: begin
          stack[cnt[pfmt_pkg::IDX_W-1:0]] <= dig;
          cnt <= cnt + 1'b1;
          mag <= quot;
          if (quot == '0) begin
            state <= ST_POP;
          end else if (radix == pfmt_pkg::RAD_DEC) begin
            state <= ST_MUL;
          end else begin
            state <= ST_DIG;
          end
        end
        ST_POP: begin
          if (can_load) begin
            out_char  <= pfmt_pkg::digit_char(stack[top_idx]);
            out_last  <= (cnt == pfmt_pkg::CNT_W'(1));
            out_unsup <= 1'b0;
            cnt       <= cnt - 1'b1;
            if (cnt == pfmt_pkg::CNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/printf_numeric_formatter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// printf_numeric_formatter
// printf-style integer formatter: format bytes in, ascii characters out
// ---------------------------------------------------------------------------
// Format bytes come in one transaction at a time, each with a 32-bit argument
// word. A front end decodes the byte (plain text, percent, conversion letter,
// terminator) and queues a command; a back end turns it into characters on an
// output register, so the two sides stall independently. Ordinary bytes, %c,
// %s (flagged unsupported, char zero) and the terminator give one character
// each. A numeric conversion splits the magnitude into digits least
// significant first onto a small digit stack, then pops them most
// significant first: hex and octal take each digit by a shift, decimal by
// a registered multiply by the reciprocal of ten, then the remainder; each
// popped digit is emitted as one character. A bare percent emits nothing;
// percent followed by zero emits the terminator.
// ---------------------------------------------------------------------------
module printf_numeric_formatter (
  input  wire logic  clk,
  input  wire logic  rst,
  pfmt_in_if.sink    in_ch,
  pfmt_out_if.source out_ch
);

  // front to queue
  logic                 push;
  pfmt_pkg::cmd_t       push_cmd;
  logic                 full;

  // queue to back
  logic                 pop;
  pfmt_pkg::cmd_t       head_cmd;
  logic                 not_empty;

  // decode side: percent tracking and command build
  pfmt_front u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .full  (full),
    .push  (push),
    .cmd   (push_cmd)
  );

  // decoupling queue
  pfmt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .head_cmd  (head_cmd),
    .not_empty (not_empty)
  );

  // digit engine and output register
  pfmt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (head_cmd),
    .cmd_valid (not_empty),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire
